[src/frame_pacing_deadline_budget_macros.svh]
// Assertion macros for the frame pacing budget checker.
`ifndef FRAME_PACING_DEADLINE_BUDGET_MACROS_SVH
`define FRAME_PACING_DEADLINE_BUDGET_MACROS_SVH

// Same-cycle implication, masked while rst is high.
`define FPDB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked during reset.
`define FPDB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/fpdb_pkg.sv]
// Types and constants for the frame pacing deadline budget block.
package fpdb_pkg;

  localparam int unsigned BYTES_W   = 32;
  localparam int unsigned RATE_W    = 32;
  localparam int unsigned RTT_W     = 16;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned GUARD_W   = 11;
  localparam int unsigned QUOT_W    = 16;
  localparam int unsigned PROD_W    = RATE_W + MS_W;
  localparam int unsigned GSUM_W    = RTT_W + 2;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned IN_W      = 88;
  localparam int unsigned OUT_W     = 48;

  localparam int unsigned GUARD_BASE_MS = 100;
  localparam logic [GUARD_W-1:0] GUARD_MIN_MS = 11'd250;
  localparam logic [GUARD_W-1:0] GUARD_MAX_MS = 11'd2000;

  localparam logic [MS_W-1:0] NORMAL_DEADLINE_RESET   = 16'd4000;
  localparam logic [MS_W-1:0] RECOVERY_DEADLINE_RESET = 16'd8000;

  // Register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_DEADLINE   = 8'd0,
    REG_RECOVERY_DEADLINE = 8'd1
  } cfg_reg_t;

  // Per-frame context carried alongside the divider
  typedef struct packed {
    logic               no_budget;
    logic               too_large;
    logic [GUARD_W-1:0] guard;
    logic [MS_W-1:0]    limit;
    logic [MS_W-1:0]    maxd;
  } fpdb_ctx_t;

  // Restoring divider state: remainder, divisor, and the shared
  // dividend/quotient shift register
  typedef struct packed {
    logic [RATE_W-1:0] divisor;
    logic [RATE_W-1:0] rem;
    logic [QUOT_W-1:0] qbits;
  } fpdb_div_t;

  typedef struct packed {
    fpdb_ctx_t ctx;
    fpdb_div_t div;
  } fpdb_item_t;

endpackage

[src/frame_pacing_deadline_budget.sv]
// Top level of the frame pacing deadline budget pipeline.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  s_tdata: frame request
//   m_       out  m_tvalid/m_tready  m_tdata: budget result
//   cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data: deadline registers
//
// One request enters per cycle while the output is not stalled; each result passes
// through 3 front stages, 16 divider cells and 1 output register.
// The pacing quotient is built one bit per cell along the divider chain.
// Reset empties every stage and loads the default deadlines.
// Each stage holds its request while the next one is full and stalled,
// so bubbles close up and input is taken whenever a slot frees.
// cfg_ready is always high; writes take effect on the next request.
module frame_pacing_deadline_budget import fpdb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata: frame_bytes[31:0], rate_kbps[63:32], rtt_ms[79:64],
  //          is_recovery[80], zero pad[87:81]
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata: no_budget[0], guard_ms[11:1], pacing_ms[27:12],
  //          due_ms[43:28], fits_deadline[44], zero pad[47:45]
  output logic [OUT_W-1:0]     m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MS_W-1:0]      cfg_data
);

  logic [MS_W-1:0] normal_deadline_ms;
  logic [MS_W-1:0] recovery_deadline_ms;

  logic               chain_valid [QUOT_W+1];
  logic               chain_ready [QUOT_W+1];
  fpdb_item_t         chain_item  [QUOT_W+1];

  logic               no_budget;
  logic [GUARD_W-1:0] guard_ms;
  logic [MS_W-1:0]    pacing_ms;
  logic [MS_W-1:0]    due_ms;
  logic               fits_deadline;

  // Deadline registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_deadline_ms   <= NORMAL_DEADLINE_RESET;
      recovery_deadline_ms <= RECOVERY_DEADLINE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NORMAL_DEADLINE:   normal_deadline_ms   <= cfg_data;
        REG_RECOVERY_DEADLINE: recovery_deadline_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  fpdb_front u_front (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (s_tvalid),
    .in_ready             (s_tready),
    .frame_bytes          (s_tdata[31:0]),
    .rate_kbps            (s_tdata[63:32]),
    .rtt_ms               (s_tdata[79:64]),
    .is_recovery          (s_tdata[80]),
    .normal_deadline_ms   (normal_deadline_ms),
    .recovery_deadline_ms (recovery_deadline_ms),
    .out_valid            (chain_valid[0]),
    .out_ready            (chain_ready[0]),
    .out_item             (chain_item[0])
  );

  // Divider chain, most significant quotient bit first
  for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
    fpdb_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_item   (chain_item[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_item  (chain_item[i+1])
    );
  end

  fpdb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (chain_valid[QUOT_W]),
    .in_ready      (chain_ready[QUOT_W]),
    .in_item       (chain_item[QUOT_W]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .no_budget     (no_budget),
    .guard_ms      (guard_ms),
    .pacing_ms     (pacing_ms),
    .due_ms        (due_ms),
    .fits_deadline (fits_deadline)
  );

  assign m_tdata = {3'b000, fits_deadline, due_ms, pacing_ms, guard_ms, no_budget};

endmodule

[src/fpdb_front.sv]
// Front stages: guard, deadline limit, byte-capacity product, oversize check.
module fpdb_front import fpdb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BYTES_W-1:0] frame_bytes,
  input  logic [RATE_W-1:0]  rate_kbps,
  input  logic [RTT_W-1:0]   rtt_ms,
  input  logic               is_recovery,
  input  logic [MS_W-1:0]    normal_deadline_ms,
  input  logic [MS_W-1:0]    recovery_deadline_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output fpdb_item_t         out_item
);

  logic               v1, v2, v3;
  logic               r1, r2, r3;
  logic [BYTES_W-1:0] bytes1, bytes2;
  logic [RATE_W-1:0]  rate1, rate2;
  fpdb_ctx_t          ctx1, ctx2;
  logic [PROD_W-1:0]  prod2;
  fpdb_item_t         item3;
  fpdb_ctx_t          ctx_next;

  logic [GSUM_W-1:0]  gsum;
  logic [GUARD_W-1:0] guard_c;
  logic [MS_W-1:0]    maxd_c;
  logic [MS_W-1:0]    guard_ext;
  logic [BYTES_W+2:0] dividend;

  // Stage readiness: a stage takes a request when empty or draining
  assign r3       = !v3 || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  // Guard = 2*rtt + 100 clamped, and the selected maximum deadline
  always_comb begin
    gsum = {1'b0, rtt_ms, 1'b0} + GSUM_W'(GUARD_BASE_MS);
    if (gsum < GSUM_W'(GUARD_MIN_MS)) begin
      guard_c = GUARD_MIN_MS;
    end else if (gsum > GSUM_W'(GUARD_MAX_MS)) begin
      guard_c = GUARD_MAX_MS;
    end else begin
      guard_c = gsum[GUARD_W-1:0];
    end
    maxd_c    = is_recovery ? recovery_deadline_ms : normal_deadline_ms;
    guard_ext = MS_W'(guard_c);
  end

  // Stage 1: guard, limit, zero check
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= in_valid;
    end
    if (r1 && in_valid) begin
      bytes1            <= frame_bytes;
      rate1             <= rate_kbps;
      ctx1.no_budget    <= (frame_bytes == '0) || (rate_kbps == '0);
      ctx1.too_large    <= 1'b0;
      ctx1.guard        <= guard_c;
      ctx1.maxd         <= maxd_c;
      ctx1.limit        <= (maxd_c > guard_ext) ? (maxd_c - guard_ext) : '0;
    end
  end

  // Stage 2: rate * limit; bytes that fit = product / 8
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
    if (r2 && v1) begin
      bytes2 <= bytes1;
      rate2  <= rate1;
      ctx2   <= ctx1;
      prod2  <= PROD_W'(rate1) * PROD_W'(ctx1.limit);
    end
  end

  // Stage 3: oversize compare and divider seed for ceil(8*bytes / rate)
  assign dividend = {bytes2, 3'b000};

  always_comb begin
    ctx_next           = ctx2;
    ctx_next.too_large = (PROD_W'(bytes2) > (prod2 >> 3));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
    if (r3 && v2) begin
      item3.ctx           <= ctx_next;
      item3.div.divisor   <= rate2;
      item3.div.rem       <= RATE_W'(dividend[BYTES_W+2:QUOT_W]);
      item3.div.qbits     <= dividend[QUOT_W-1:0];
    end
  end

  assign out_valid = v3;
  assign out_item  = item3;

endmodule

[src/fpdb_div_cell.sv]
// One restoring-division cell: retires one quotient bit per request.
module fpdb_div_cell import fpdb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  fpdb_item_t in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output fpdb_item_t out_item
);

  logic              valid;
  fpdb_item_t        item;
  logic [RATE_W:0]   trial;
  logic [RATE_W:0]   diff;
  logic              ge;
  fpdb_item_t        item_next;

  assign in_ready = !valid || out_ready;

  // Shift next dividend bit into the remainder, subtract if it fits
  always_comb begin
    trial     = {in_item.div.rem, in_item.div.qbits[QUOT_W-1]};
    diff      = trial - {1'b0, in_item.div.divisor};
    ge        = (trial >= {1'b0, in_item.div.divisor});
    item_next = in_item;
    item_next.div.rem   = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
    item_next.div.qbits = {in_item.div.qbits[QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

[src/fpdb_back.sv]
// Output stage: ceiling, deadline and fit decision, result register.
module fpdb_back import fpdb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpdb_item_t         in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               no_budget,
  output logic [GUARD_W-1:0] guard_ms,
  output logic [MS_W-1:0]    pacing_ms,
  output logic [MS_W-1:0]    due_ms,
  output logic               fits_deadline
);

  logic               valid;
  logic [MS_W:0]      pace_ceil;
  logic [MS_W:0]      total;
  logic               fits_c;
  logic               no_budget_next;
  logic [GUARD_W-1:0] guard_next;
  logic [MS_W-1:0]    pacing_next;
  logic [MS_W-1:0]    deadline_next;
  logic               fits_next;

  assign in_ready = !valid || out_ready;

  // Round the quotient up, then check pacing + guard against the maximum
  always_comb begin
    pace_ceil = {1'b0, in_item.div.qbits} + (MS_W+1)'(in_item.div.rem != '0);
    total     = {1'b0, pace_ceil[MS_W-1:0]} + (MS_W+1)'(in_item.ctx.guard);
    fits_c    = (total <= {1'b0, in_item.ctx.maxd});

    no_budget_next = 1'b0;
    guard_next     = in_item.ctx.guard;
    if (in_item.ctx.no_budget) begin
      no_budget_next = 1'b1;
      guard_next     = '0;
      pacing_next    = '0;
      deadline_next  = '0;
      fits_next      = 1'b0;
    end else if (in_item.ctx.too_large) begin
      pacing_next    = in_item.ctx.limit + MS_W'(1);
      deadline_next  = in_item.ctx.maxd;
      fits_next      = 1'b0;
    end else begin
      pacing_next    = pace_ceil[MS_W-1:0];
      deadline_next  = fits_c ? total[MS_W-1:0] : in_item.ctx.maxd;
      fits_next      = fits_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      no_budget     <= no_budget_next;
      guard_ms      <= guard_next;
      pacing_ms     <= pacing_next;
      due_ms        <= deadline_next;
      fits_deadline <= fits_next;
    end
  end

  assign out_valid = valid;

endmodule

[src/fpdb_checker.sv]
// Port-level checks for the frame pacing deadline budget block, with bind.
`include "frame_pacing_deadline_budget_macros.svh"

module fpdb_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  logic [16:0] fit_sum;

  // pacing + guard, for the fitting case
  assign fit_sum = {1'b0, m_tdata[27:12]} + {6'b0, m_tdata[11:1]};

  // Reset empties the pipeline
  `FPDB_ASSERT_NEXT(a_reset_empty, rst, !m_tvalid, "result valid right after reset")

  // A stalled result stays put
  `FPDB_ASSERT_NOW(a_hold, m_tvalid && !m_tready && $past(m_tvalid && !m_tready) && !$past(rst), $stable(m_tdata), "stalled result changed")

  // No budget zeroes every other field
  `FPDB_ASSERT_NOW(a_no_budget_zero, m_tvalid && m_tdata[0], m_tdata[47:1] == '0, "no_budget result has nonzero fields")

  // Guard stays in its clamp window when a budget exists
  `FPDB_ASSERT_NOW(a_guard_range, m_tvalid && !m_tdata[0], (m_tdata[11:1] >= 11'd250) && (m_tdata[11:1] <= 11'd2000), "guard outside clamp")

  // A fitting frame reports pacing plus guard as its deadline
  `FPDB_ASSERT_NOW(a_fit_sum, m_tvalid && m_tdata[44], fit_sum == {1'b0, m_tdata[43:28]}, "fitting deadline mismatch")

endmodule

bind frame_pacing_deadline_budget fpdb_checker u_fpdb_checker (.*);
